### hdl/htw_pkg.sv
// ----------------------------------------------------------------------------
// htw_pkg: shared constants and codes for the hashed timing wheel
// Widths of the fixed fields, operation codes and register indexes.
// ----------------------------------------------------------------------------
package htw_pkg;

  localparam int NUM_TIMERS_DEF = 32;
  localparam int MAX_SLOTS_DEF  = 256;

  localparam int TIME_W     = 26;  // ticks, rounds and period
  localparam int DIVIDEND_W = 27;  // ticks plus current slot
  localparam int DIVISOR_W  = 16;
  localparam int MODE_W     = 2;
  localparam int ID_IN_W    = 5;
  localparam int SEC_W      = 16;
  localparam int MS_W       = 16;
  localparam int SLOTS_CFG_W = 9;
  localparam int TICK_CFG_W = 16;
  localparam int CFG_W      = 16;
  localparam int OUT_LIMIT  = 32;
  localparam int OUT_CNT_W  = $clog2(OUT_LIMIT + 1);
  localparam int MS_PER_SEC = 1000;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  localparam logic [SLOTS_CFG_W-1:0] SLOTS_RESET = 9'd256;
  localparam logic [TICK_CFG_W-1:0]  TICK_RESET  = 16'd10;

  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_DEL  = 2'd1,
    MODE_TICK = 2'd2,
    MODE_NOP  = 2'd3
  } mode_e;

  typedef enum logic {
    REG_SLOTS   = 1'b0,
    REG_TICK_MS = 1'b1
  } reg_e;

endpackage

### hdl/htw_div.sv
// ----------------------------------------------------------------------------
// htw_div: restoring divider, one quotient bit per cycle
// Quotient and remainder hold after done until the next start.
// ----------------------------------------------------------------------------
module htw_div #(
  parameter int DW = htw_pkg::DIVIDEND_W,
  parameter int VW = htw_pkg::DIVISOR_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o,
  output logic [VW-1:0] rem_o
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_q;
  logic [VW:0]   rem_q;
  logic [VW-1:0] dvs_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [VW:0]   trial, diff;
  logic          fits;

  assign trial = {rem_q[VW-1:0], quo_q[DW-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff : trial;
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q[VW-1:0];

endmodule

### hdl/htw_cell.sv
// ----------------------------------------------------------------------------
// htw_cell: one timer entry of the ring
// Loads from the write bus, clears its live bit, or takes its neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module htw_cell #(
  parameter int SLOT_W = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      shift_i,
  input  logic                      nb_live_i,
  input  logic [SLOT_W-1:0]         nb_slot_i,
  input  logic [htw_pkg::TIME_W-1:0] nb_rounds_i,
  input  logic [htw_pkg::TIME_W-1:0] nb_period_i,
  input  logic                      nb_rep_i,
  input  logic                      wr_i,
  input  logic                      clr_i,
  input  logic [SLOT_W-1:0]         wr_slot_i,
  input  logic [htw_pkg::TIME_W-1:0] wr_rounds_i,
  input  logic [htw_pkg::TIME_W-1:0] wr_period_i,
  input  logic                      wr_rep_i,
  output logic                      live_o,
  output logic [SLOT_W-1:0]         slot_o,
  output logic [htw_pkg::TIME_W-1:0] rounds_o,
  output logic [htw_pkg::TIME_W-1:0] period_o,
  output logic                      rep_o
);

  logic                       live_q;
  logic [SLOT_W-1:0]          slot_q;
  logic [htw_pkg::TIME_W-1:0] rounds_q, period_q;
  logic                       rep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else if (shift_i) begin
      live_q <= nb_live_i;
    end else if (wr_i) begin
      live_q <= 1'b1;
    end else if (clr_i) begin
      live_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      slot_q   <= nb_slot_i;
      rounds_q <= nb_rounds_i;
      period_q <= nb_period_i;
      rep_q    <= nb_rep_i;
    end else if (wr_i) begin
      slot_q   <= wr_slot_i;
      rounds_q <= wr_rounds_i;
      period_q <= wr_period_i;
      rep_q    <= wr_rep_i;
    end
  end

  assign live_o   = live_q;
  assign slot_o   = slot_q;
  assign rounds_o = rounds_q;
  assign period_o = period_q;
  assign rep_o    = rep_q;

endmodule

### hdl/hashed_timing_wheel_top.sv
// ----------------------------------------------------------------------------
// hashed_timing_wheel_top: hashed timing wheel over a ring of timer cells
//
//   channel   dir  beat contents
//   s_axis    in   tuser: mode; tdata: timer_id, seconds, millis, repeat_req
//   m_axis    out  tdata: expired_id; tlast: last expiry of the tick
//   cfg       in   cfg_addr_i 0 slots_in_use, 1 tick_ms
//
// Add: the shared bit-serial divider computes ms/tick, then
// (ticks+current)%slots and ticks/slots. Tick: the divider advances the
// slot, then the ring rotates once past the head cell, then a flush state;
// a repeating expiry is re-armed with the last two divisions of Add.
// Delete needs no divider. A full output register stalls the rotation.
// Reset clears the live bits and control; entry payload is not reset.
// ----------------------------------------------------------------------------
module hashed_timing_wheel_top #(
  parameter int NUM_TIMERS = htw_pkg::NUM_TIMERS_DEF,
  parameter int MAX_SLOTS  = htw_pkg::MAX_SLOTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // timer_id[4:0], seconds[20:5], millis[36:21], repeat_req[37], zero [39:38]
  input  logic [htw_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // mode[1:0]
  input  logic [htw_pkg::MODE_W-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // expired_id[4:0], zero [7:5]
  output logic [htw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast,
  input  logic                              cfg_we_i,
  input  logic                              cfg_addr_i,
  input  logic [htw_pkg::CFG_W-1:0]         cfg_wdata_i
);

  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int CNT_W  = $clog2(NUM_TIMERS + 1);
  localparam int TW     = htw_pkg::TIME_W;
  localparam int DW     = htw_pkg::DIVIDEND_W;
  localparam int VW     = htw_pkg::DIVISOR_W;
  localparam int OCW    = htw_pkg::OUT_CNT_W;
  localparam int IDW    = htw_pkg::ID_IN_W;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DIVT  = 7'b0000010,
    ST_ARMS  = 7'b0000100,
    ST_ARMR  = 7'b0001000,
    ST_TADV  = 7'b0010000,
    ST_SCAN  = 7'b0100000,
    ST_FLUSH = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // input fields
  htw_pkg::mode_e           in_mode;
  logic [IDW-1:0]           in_id;
  logic [htw_pkg::SEC_W-1:0] in_sec;
  logic [htw_pkg::MS_W-1:0]  in_ms;
  logic                     in_rep;
  assign in_mode = htw_pkg::mode_e'(s_axis_tuser);
  assign in_id   = s_axis_tdata[4:0];
  assign in_sec  = s_axis_tdata[20:5];
  assign in_ms   = s_axis_tdata[36:21];
  assign in_rep  = s_axis_tdata[37];

  logic [htw_pkg::SLOTS_CFG_W-1:0] slots_q;
  logic [htw_pkg::TICK_CFG_W-1:0]  tickms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q  <= htw_pkg::SLOTS_RESET;
      tickms_q <= htw_pkg::TICK_RESET;
    end else if (cfg_we_i) begin
      case (htw_pkg::reg_e'(cfg_addr_i))
        htw_pkg::REG_SLOTS:   slots_q  <= cfg_wdata_i[htw_pkg::SLOTS_CFG_W-1:0];
        htw_pkg::REG_TICK_MS: tickms_q <= cfg_wdata_i[htw_pkg::TICK_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  logic [VW-1:0] eff_s, eff_tm;
  always_comb begin
    if (slots_q == '0) eff_s = VW'(1);
    else if (VW'(slots_q) > VW'(MAX_SLOTS)) eff_s = VW'(MAX_SLOTS);
    else eff_s = VW'(slots_q);
    eff_tm = (tickms_q == '0) ? VW'(1) : VW'(tickms_q);
  end

  // registers
  logic [IDW-1:0]    id_q, id_d;
  logic              rep_q, rep_d;
  logic [TW-1:0]     total_q, total_d, ticks_q, ticks_d;
  logic [SLOT_W-1:0] nslot_q, nslot_d, cur_q, cur_d;
  logic [CNT_W-1:0]  scan_q, scan_d;
  logic [OCW-1:0]    ocnt_q, ocnt_d;
  logic              pend_v_q, pend_v_d;
  logic [IDW-1:0]    pend_id_q, pend_id_d;
  logic              out_v_q;
  logic [IDW-1:0]    out_id_q;
  logic              out_last_q;
  logic              run_q, run_d, inscan_q, inscan_d;

  // divider
  logic          div_start, div_done;
  logic [DW-1:0] div_a, div_quo;
  logic [VW-1:0] div_b, div_rem;

  always_comb begin
    div_a = DW'(total_q);
    div_b = eff_tm;
    case (state_q)
      ST_ARMS: begin div_a = DW'(ticks_q) + DW'(cur_q); div_b = eff_s; end
      ST_ARMR: begin div_a = DW'(ticks_q); div_b = eff_s; end
      ST_TADV: begin div_a = DW'(cur_q) + DW'(1); div_b = eff_s; end
      default: ;
    endcase
  end

  htw_div #(.DW(DW), .VW(VW)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_a), .divisor_i(div_b),
    .done_o(div_done), .quot_o(div_quo), .rem_o(div_rem)
  );

  // cell ring: cell 0 is the head, the tail takes the processed head entry
  logic              c_live [NUM_TIMERS+1];
  logic [SLOT_W-1:0] c_slot [NUM_TIMERS+1];
  logic [TW-1:0]     c_rnd  [NUM_TIMERS+1];
  logic [TW-1:0]     c_per  [NUM_TIMERS+1];
  logic              c_rep  [NUM_TIMERS+1];

  logic              shift_en, wr_en, clr_en;
  logic              e_live, e_rep;
  logic [SLOT_W-1:0] e_slot;
  logic [TW-1:0]     e_rnd, e_per;

  assign c_live[NUM_TIMERS] = e_live;
  assign c_slot[NUM_TIMERS] = e_slot;
  assign c_rnd[NUM_TIMERS]  = e_rnd;
  assign c_per[NUM_TIMERS]  = e_per;
  assign c_rep[NUM_TIMERS]  = e_rep;

  for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
    logic wr_k, clr_k;
    assign wr_k  = wr_en && (32'(id_q) == k);
    assign clr_k = clr_en && (32'(in_id) == k);
    htw_cell #(.SLOT_W(SLOT_W)) u_cell (
      .clk_i, .rst_ni,
      .shift_i(shift_en),
      .nb_live_i(c_live[k+1]), .nb_slot_i(c_slot[k+1]), .nb_rounds_i(c_rnd[k+1]),
      .nb_period_i(c_per[k+1]), .nb_rep_i(c_rep[k+1]),
      .wr_i(wr_k), .clr_i(clr_k),
      .wr_slot_i(e_slot), .wr_rounds_i(e_rnd), .wr_period_i(e_per), .wr_rep_i(e_rep),
      .live_o(c_live[k]), .slot_o(c_slot[k]), .rounds_o(c_rnd[k]),
      .period_o(c_per[k]), .rep_o(c_rep[k])
    );
  end

  logic out_free, push, push_last, hit, id_ok, last_scan, report;
  logic [IDW-1:0] push_id;

  assign out_free  = !out_v_q || m_axis_tready;
  assign hit       = c_live[0] && (c_slot[0] == cur_q);
  assign id_ok     = 32'(in_id) < NUM_TIMERS;
  assign last_scan = scan_q == CNT_W'(NUM_TIMERS - 1);
  assign report    = ocnt_q < OCW'(htw_pkg::OUT_LIMIT);

  always_comb begin
    state_d = state_q;
    id_d = id_q; rep_d = rep_q; total_d = total_q; ticks_d = ticks_q;
    nslot_d = nslot_q; cur_d = cur_q; scan_d = scan_q; ocnt_d = ocnt_q;
    pend_v_d = pend_v_q; pend_id_d = pend_id_q; run_d = run_q; inscan_d = inscan_q;
    div_start = 1'b0; shift_en = 1'b0; wr_en = 1'b0; clr_en = 1'b0;
    push = 1'b0; push_id = pend_id_q; push_last = 1'b0;
    e_live = c_live[0]; e_slot = c_slot[0]; e_rnd = c_rnd[0];
    e_per = c_per[0]; e_rep = c_rep[0];

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          case (in_mode)
            htw_pkg::MODE_ADD: begin
              if (id_ok) begin
                id_d    = in_id;
                rep_d   = in_rep;
                total_d = TW'(in_sec) * TW'(htw_pkg::MS_PER_SEC) + TW'(in_ms);
                inscan_d = 1'b0;
                state_d = ST_DIVT;
              end
            end
            htw_pkg::MODE_DEL:  clr_en = id_ok;
            htw_pkg::MODE_TICK: state_d = ST_TADV;
            default: ;
          endcase
        end
      end
      ST_DIVT, ST_ARMS, ST_ARMR, ST_TADV: begin
        if (!run_q) begin
          div_start = 1'b1;
          run_d = 1'b1;
        end else if (div_done) begin
          run_d = 1'b0;
          case (state_q)
            ST_DIVT: begin
              ticks_d = div_quo[TW-1:0];
              state_d = ST_ARMS;
            end
            ST_ARMS: begin
              nslot_d = div_rem[SLOT_W-1:0];
              state_d = ST_ARMR;
            end
            ST_ARMR: begin
              e_live = 1'b1;
              e_slot = nslot_q;
              e_rnd  = div_quo[TW-1:0];
              e_per  = ticks_q;
              if (inscan_q) begin
                shift_en = 1'b1;
                scan_d   = scan_q + 1'b1;
                state_d  = last_scan ? ST_FLUSH : ST_SCAN;
              end else begin
                e_rep   = rep_q;
                wr_en   = 1'b1;
                state_d = ST_IDLE;
              end
            end
            default: begin // slot advance
              cur_d    = div_rem[SLOT_W-1:0];
              scan_d   = '0;
              ocnt_d   = '0;
              inscan_d = 1'b1;
              state_d  = ST_SCAN;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (hit && c_rnd[0] == '0) begin
          if (!(report && pend_v_q && !out_free)) begin
            if (report) begin
              push      = pend_v_q;
              pend_v_d  = 1'b1;
              pend_id_d = IDW'(scan_q);
              ocnt_d    = ocnt_q + 1'b1;
            end
            if (c_rep[0]) begin
              ticks_d = c_per[0];
              state_d = ST_ARMS;
            end else begin
              e_live   = 1'b0;
              shift_en = 1'b1;
              scan_d   = scan_q + 1'b1;
              if (last_scan) state_d = ST_FLUSH;
            end
          end
        end else begin
          if (hit) e_rnd = c_rnd[0] - 1'b1;
          shift_en = 1'b1;
          scan_d   = scan_q + 1'b1;
          if (last_scan) state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        inscan_d = 1'b0;
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          pend_v_d  = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cur_q    <= '0;
      scan_q   <= '0;
      ocnt_q   <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      run_q    <= 1'b0;
      inscan_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cur_q    <= cur_d;
      scan_q   <= scan_d;
      ocnt_q   <= ocnt_d;
      pend_v_q <= pend_v_d;
      run_q    <= run_d;
      inscan_q <= inscan_d;
      if (push) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q      <= id_d;
    rep_q     <= rep_d;
    total_q   <= total_d;
    ticks_q   <= ticks_d;
    nslot_q   <= nslot_d;
    pend_id_q <= pend_id_d;
    if (push) begin
      out_id_q   <= push_id;
      out_last_q <= push_last;
    end
  end

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = htw_pkg::OUT_TDATA_W'(out_id_q);
  assign m_axis_tlast  = out_last_q;

endmodule
